/* sv/source_text_tokenizer_top_assert.svh */
// assertion macros for the source text tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define STT_ASSERT_IMPL(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("tokenizer assertion failed");

// condition implies consequence in the next cycle
`define STT_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

/* sv/stt_pkg.sv */
// types, constants and character helpers for the source text tokenizer
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int ROW_BITS    = 20;
    localparam int COLUMN_BITS = 16;
    localparam int WINDOW_BITS = 56;
    localparam int KW_COUNT    = 25;
    localparam int KW_MAX_LEN  = 7;

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
    localparam logic [ROW_BITS-1:0]    ROW_MAX    = '1;
    localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;

    localparam logic [WINDOW_BITS-1:0] KEYWORDS [KW_COUNT] = '{
        56'("if"), 56'("else"), 56'("for"), 56'("while"), 56'("int"),
        56'("float"), 56'("string"), 56'("void"), 56'("return"), 56'("auto"),
        56'("const"), 56'("case"), 56'("class"), 56'("private"), 56'("public"),
        56'("default"), 56'("break"), 56'("enum"), 56'("static"), 56'("sizeof"),
        56'("do"), 56'("delete"), 56'("try"), 56'("catch"), 56'("throw")
    };

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OPER   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_KEYWORD  = 3'd0,
        KIND_IDENT    = 3'd1,
        KIND_INTEGER  = 3'd2,
        KIND_FLOAT    = 3'd3,
        KIND_OPERATOR = 3'd4,
        KIND_PUNCT    = 3'd5,
        KIND_INVALID  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [LENGTH_BITS-1:0] length;
        logic [ROW_BITS-1:0]    row;
        logic [COLUMN_BITS-1:0] column;
        logic                   dots;
        logic                   last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_lex_out;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7e && !is_alpha(c) && !is_digit(c);
    endfunction

    function automatic logic is_op_pending(input logic [7:0] c);
        return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f;
    endfunction

    function automatic logic is_op_single(input logic [7:0] c);
        return c == 8'h3c || c == 8'h3e || c == 8'h3d || c == 8'h21 ||
               c == 8'h26 || c == 8'h7c || c == 8'h25;
    endfunction

    function automatic logic is_keyword(input logic [WINDOW_BITS-1:0] w);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = hit | (w == KEYWORDS[i]);
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

/* sv/stt_lexer.sv */
// scan state and token classification for one character per cycle while i_take is high
`timescale 1ns / 1ps
`default_nettype none
module stt_lexer
    import stt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire logic [7:0] i_char,
    input  wire logic     i_eot,
    output t_lex_out      o_res
);

    t_mode                  r_mode, n_mode;
    logic [WINDOW_BITS-1:0] r_window, n_window;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_dot, n_dot;
    logic                   r_dot2, n_dot2;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0]    r_srow, n_srow;
    logic [COLUMN_BITS-1:0] r_scol, n_scol;

    logic [LENGTH_BITS-1:0] len_inc;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [ROW_BITS-1:0]    row_inc;
    logic                   ident_cont, num_cont, op_cont;
    logic                   pend_emit, single_emit;
    logic [LENGTH_BITS-1:0] pend_len;
    t_kind                  pend_kind, single_kind;
    t_token                 pend_tok, single_tok;

    assign len_inc = (r_len == LENGTH_MAX) ? r_len : r_len + 1'b1;
    assign col_inc = (r_col == COLUMN_MAX) ? r_col : r_col + 1'b1;
    assign row_inc = (r_row == ROW_MAX) ? r_row : r_row + 1'b1;

    assign ident_cont = (r_mode == MODE_IDENT) &&
                        (is_alpha(i_char) || is_digit(i_char) || i_char == CH_UNDER);
    assign num_cont   = (r_mode == MODE_NUMBER) && (is_digit(i_char) || i_char == CH_DOT);
    assign op_cont    = (r_mode == MODE_OPER) && (i_char == CH_EQUAL);

    always_comb begin
        n_mode      = r_mode;
        n_window    = r_window;
        n_len       = r_len;
        n_dot       = r_dot;
        n_dot2      = r_dot2;
        n_row       = r_row;
        n_col       = r_col;
        n_srow      = r_srow;
        n_scol      = r_scol;
        pend_emit   = 1'b0;
        single_emit = 1'b0;
        pend_len    = r_len;
        single_kind = KIND_INVALID;
        priority if (i_eot) begin
            pend_emit = (r_mode != MODE_IDLE);
            n_mode    = MODE_IDLE;
        end else if (ident_cont) begin
            n_window = {r_window[WINDOW_BITS-9:0], i_char};
            n_len    = len_inc;
            n_col    = col_inc;
        end else if (num_cont) begin
            if (i_char == CH_DOT) begin
                n_dot2 = r_dot2 | r_dot;
                n_dot  = 1'b1;
            end
            n_len = len_inc;
            n_col = col_inc;
        end else if (op_cont) begin
            pend_emit = 1'b1;
            pend_len  = len_inc;
            n_len     = len_inc;
            n_col     = col_inc;
            n_mode    = MODE_IDLE;
        end else begin
            pend_emit = (r_mode != MODE_IDLE);
            n_mode    = MODE_IDLE;
            priority if (i_char == CH_NEWLINE) begin
                n_row = row_inc;
                n_col = COLUMN_BITS'(1);
            end else if (is_space(i_char)) begin
                n_col = col_inc;
            end else begin
                // every other character starts a token here
                n_srow = r_row;
                n_scol = r_col;
                n_len  = LENGTH_BITS'(1);
                n_col  = col_inc;
                priority if (is_alpha(i_char) || i_char == CH_UNDER) begin
                    n_mode   = MODE_IDENT;
                    n_window = WINDOW_BITS'(i_char);
                end else if (is_digit(i_char)) begin
                    n_mode = MODE_NUMBER;
                    n_dot  = 1'b0;
                    n_dot2 = 1'b0;
                end else if (is_op_pending(i_char)) begin
                    n_mode = MODE_OPER;
                end else begin
                    single_emit = 1'b1;
                    priority if (is_op_single(i_char)) begin
                        single_kind = KIND_OPERATOR;
                    end else if (is_punct(i_char)) begin
                        single_kind = KIND_PUNCT;
                    end else begin
                        single_kind = KIND_INVALID;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (r_mode)
            MODE_IDENT: begin
                pend_kind = ((r_len <= LENGTH_BITS'(KW_MAX_LEN)) && is_keyword(r_window))
                            ? KIND_KEYWORD : KIND_IDENT;
            end
            MODE_NUMBER: begin
                pend_kind = r_dot ? KIND_FLOAT : KIND_INTEGER;
            end
            default: begin
                pend_kind = KIND_OPERATOR;
            end
        endcase
    end

    always_comb begin
        pend_tok.kind     = pend_kind;
        pend_tok.length   = pend_len;
        pend_tok.row      = r_srow;
        pend_tok.column   = r_scol;
        pend_tok.dots     = (r_mode == MODE_NUMBER) && r_dot && r_dot2;
        pend_tok.last     = !single_emit;
        single_tok.kind   = single_kind;
        single_tok.length = LENGTH_BITS'(1);
        single_tok.row    = r_row;
        single_tok.column = r_col;
        single_tok.dots   = 1'b0;
        single_tok.last   = 1'b1;
        o_res.count       = {1'b0, pend_emit} + {1'b0, single_emit};
        o_res.first       = pend_emit ? pend_tok : single_tok;
        o_res.second      = single_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_window <= '0;
            r_len    <= '0;
            r_dot    <= 1'b0;
            r_dot2   <= 1'b0;
            r_row    <= ROW_BITS'(1);
            r_col    <= COLUMN_BITS'(1);
            r_srow   <= ROW_BITS'(1);
            r_scol   <= COLUMN_BITS'(1);
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_window <= n_window;
            r_len    <= n_len;
            r_dot    <= n_dot;
            r_dot2   <= n_dot2;
            r_row    <= n_row;
            r_col    <= n_col;
            r_srow   <= n_srow;
            r_scol   <= n_scol;
        end
    end

endmodule
`default_nettype wire

/* sv/source_text_tokenizer_top.sv */
// Source text tokenizer: takes one character request per cycle and returns
// token results (kind, length, start row and column) through a four-entry
// result queue. Each character is classified combinationally; a character
// that ends a pending token and is itself a one-character token yields two
// results, which drain at one per cycle while the output takes them. The input
// is ready while the queue has room for two results, so with an output that
// always takes results the block sustains one character per cycle; a run of
// characters that each yield two results is limited by the single output
// port to one result per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "source_text_tokenizer_top_assert.svh"
module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // text_char
    input  wire logic [0:0]  i_s_tuser,   // end_of_text
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,   // token_length, token_row, token_column, zero fill
    output logic [3:0]       o_m_tuser,   // token_kind, multiple_dots
    output logic             o_m_tlast    // last_of_run
);

    localparam int Q_DEPTH = 4;

    t_lex_out   lex;
    t_token     r_q [Q_DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count, n_count;
    logic       take, pop;
    t_token     head;

    assign o_s_tready = (r_count <= 3'(Q_DEPTH - 2));
    assign take       = i_s_tvalid && o_s_tready;
    assign pop        = o_m_tvalid && i_m_tready;

    stt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_s_tdata),
        .i_eot   (i_s_tuser[0]),
        .o_res   (lex)
    );

    always_comb begin
        n_count = r_count;
        if (take) begin
            n_count = n_count + {1'b0, lex.count};
        end
        if (pop) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && lex.count != 2'd0) begin
            r_q[r_wr] <= lex.first;
            if (lex.count == 2'd2) begin
                r_q[r_wr + 2'd1] <= lex.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (take) begin
                r_wr <= r_wr + lex.count;
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= n_count;
        end
    end

    assign head       = r_q[r_rd];
    assign o_m_tvalid = (r_count != 3'd0);
    assign o_m_tdata  = {4'd0, head.column, head.row, head.length};
    assign o_m_tuser  = {head.dots, head.kind};
    assign o_m_tlast  = head.last;

    `STT_ASSERT_IMPL(a_queue_bound, 1'b1, r_count <= 3'(Q_DEPTH))
    `STT_ASSERT_NEXT(a_queue_grow, take && !pop, r_count == $past(r_count) + 3'($past(lex.count)))
    `STT_ASSERT_IMPL(a_second_single, lex.count == 2'd2, lex.second.length == 16'd1 && lex.first.last == 1'b0)

endmodule
`default_nettype wire
